### rtl/core/pwbr_pkg.sv
package pwbr_pkg;

   localparam int BITS_PER_FRAME = 8;
   localparam int BIT_IDX_W      = $clog2(BITS_PER_FRAME + 1);
   localparam int BIT_SEL_W      = $clog2(BITS_PER_FRAME);
   localparam int RSP_DEPTH_DEF  = 8;
   localparam int PERIOD_W       = 17;
   localparam int COUNT_W        = 16;
   localparam int CSR_IDX_W      = 2;

   localparam logic [PERIOD_W-1:0] PERIOD_MIN_RST    = PERIOD_W'(54000);
   localparam logic [PERIOD_W-1:0] PERIOD_MAX_RST    = PERIOD_W'(66000);
   localparam logic [COUNT_W-1:0]  ONE_THRESHOLD_RST = COUNT_W'(30000);

   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_MIN    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_MAX    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_THRESHOLD = 2'd2;

   localparam logic REQ_CAPTURE = 1'b0;
   localparam logic REQ_IDLE    = 1'b1;

   typedef enum logic [1:0] {
      EV_BYTE = 2'd0,
      EV_LOST = 2'd1,
      EV_CONN = 2'd2,
      EV_DISC = 2'd3
   } event_code_type;

   typedef struct packed {
      logic               req_type;
      logic [COUNT_W-1:0] high_count;
      logic [COUNT_W-1:0] low_count;
   } req_word_type;

   typedef struct packed {
      event_code_type event_code;
      logic [7:0]     data_byte;
      logic           last;
   } rsp_word_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] period_min;
      logic [PERIOD_W-1:0] period_max;
      logic [COUNT_W-1:0]  one_threshold;
   } cfg_type;

   typedef struct packed {
      logic         push0;
      logic         push1;
      rsp_word_type res0;
      rsp_word_type res1;
   } rsp_push_type;

endpackage

### rtl/core/pwbr_decoder.sv
module pwbr_decoder
   import pwbr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_word_type req_word,
   input  cfg_type      cfg,
   output rsp_push_type push
);

   logic                 stage_valid_ff;
   req_word_type         stage_word_ff;

   logic [BITS_PER_FRAME-1:0] bit_store_ff, bit_store_in;
   logic [BIT_IDX_W-1:0]      bit_index_ff, bit_index_in;
   logic                      parity_ff, parity_in;
   logic [1:0]                tally_ff, tally_in;
   logic                      link_ff, link_in;

   logic                 one_bit;
   logic                 data_bit;
   logic                 in_range;
   logic [PERIOD_W-1:0]  period;
   logic [7:0]           full_byte;
   event_code_type       toggle_code;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_word_ff <= req_word;
      end
   end

   assign one_bit  = stage_word_ff.high_count > cfg.one_threshold;
   assign data_bit = (tally_ff == 2'd2) && !parity_ff;
   assign period   = {1'b0, stage_word_ff.high_count} + {1'b0, stage_word_ff.low_count};
   assign in_range = (period < cfg.period_max) && (period > cfg.period_min);
   assign toggle_code = link_ff ? EV_DISC : EV_CONN;

   // bit_store[0] is the msb of the byte, last bit comes from the idle word
   always_comb begin
      for (int i = 0; i < BITS_PER_FRAME - 1; i++) begin
         full_byte[BITS_PER_FRAME-1-i] = bit_store_ff[i];
      end
      full_byte[0] = one_bit;
   end

   always_comb begin
      bit_store_in = bit_store_ff;
      bit_index_in = bit_index_ff;
      parity_in    = parity_ff;
      tally_in     = tally_ff;
      link_in      = link_ff;
      push         = '0;
      push.res0.event_code = EV_LOST;
      push.res1.event_code = EV_LOST;
      if (stage_valid_ff) begin
         if (stage_word_ff.req_type == REQ_CAPTURE) begin
            parity_in = !parity_ff;
            if (tally_ff != 2'd2) begin
               tally_in = tally_ff + 2'd1;
            end
            if (data_bit && (bit_index_ff < BIT_IDX_W'(BITS_PER_FRAME))) begin
               bit_index_in = bit_index_ff + BIT_IDX_W'(1);
               if (in_range) begin
                  bit_store_in[bit_index_ff[BIT_SEL_W-1:0]] = one_bit;
               end
            end
         end else if (tally_ff == 2'd2) begin
            bit_index_in = '0;
            tally_in     = '0;
            parity_in    = 1'b0;
            push.push0   = 1'b1;
            if (bit_index_ff == BIT_IDX_W'(BITS_PER_FRAME - 1)) begin
               bit_store_in[BITS_PER_FRAME-1] = one_bit;
               push.res0.event_code = EV_BYTE;
               push.res0.data_byte  = full_byte;
               push.res0.last       = 1'b1;
               link_in              = 1'b1;
            end else if (parity_ff) begin
               // lost byte, then the link toggles
               push.push1           = 1'b1;
               push.res1.event_code = toggle_code;
               push.res1.last       = 1'b1;
               link_in              = !link_ff;
            end else begin
               push.res0.last = 1'b1;
            end
         end else if (tally_ff == 2'd1) begin
            bit_index_in         = '0;
            tally_in             = '0;
            parity_in            = 1'b0;
            push.push0           = 1'b1;
            push.res0.event_code = toggle_code;
            push.res0.last       = 1'b1;
            link_in              = !link_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_store_ff <= '0;
         bit_index_ff <= '0;
         parity_ff    <= 1'b0;
         tally_ff     <= '0;
         link_ff      <= 1'b0;
      end else begin
         bit_store_ff <= bit_store_in;
         bit_index_ff <= bit_index_in;
         parity_ff    <= parity_in;
         tally_ff     <= tally_in;
         link_ff      <= link_in;
      end
   end

endmodule

### rtl/core/pwbr_rsp_fifo.sv
module pwbr_rsp_fifo
   import pwbr_pkg::*;
#(
   parameter int RSP_DEPTH = RSP_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  rsp_push_type push,
   input  logic         pop,
   output logic         room,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   rsp_word_type           mem_ff [RSP_DEPTH];
   logic [PTR_W-1:0]       wptr_ff, wptr_in;
   logic [PTR_W-1:0]       rptr_ff, rptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [PTR_W-1:0]       wptr_next;
   logic [1:0]             n_push;

   assign wptr_next = wptr_ff + PTR_W'(1);
   assign n_push    = {1'b0, push.push0} + {1'b0, push.push1};

   always_comb begin
      wptr_in  = wptr_ff + PTR_W'(n_push);
      rptr_in  = pop ? rptr_ff + PTR_W'(1) : rptr_ff;
      count_in = count_ff + CNT_W'(n_push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.push0) begin
         mem_ff[wptr_ff] <= push.res0;
      end
      if (push.push1) begin
         mem_ff[wptr_next] <= push.res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // room for the word in the stage and one more, two results each
   assign room      = count_ff <= CNT_W'(RSP_DEPTH - 4);
   assign rsp_valid = count_ff != '0;
   assign rsp_word  = mem_ff[rptr_ff];

endmodule

### rtl/core/pwm_width_byte_receiver_unit.sv
// Pulse-width byte receiver. Capture words (high and low count of one period)
// and idle words enter on req_; every second capture after the first is a data
// bit, and an idle word closes the frame with a byte, a lost-byte report and/or
// a connect/disconnect event on rsp_. One word is accepted per cycle unless
// req_stall is high (the response queue holds over RSP_DEPTH - 4 words). An
// idle word can give two results, which leave one per cycle unless rsp_stall is
// high, through the queue's single read port. Thresholds go via csr_ (always
// ready); the user writes them only when idle, which the block doesn't enforce.
module pwm_width_byte_receiver_unit
   import pwbr_pkg::*;
#(
   parameter int RSP_DEPTH = RSP_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_word_type         req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_word_type         rsp_word,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PERIOD_W-1:0]  csr_wdata
);

   cfg_type      cfg_ff;
   rsp_push_type push;
   logic         room;
   logic         accept;
   logic         pop;

   assign csr_ready = 1'b1;
   assign req_stall = !room;
   assign accept    = req_valid && room;
   assign pop       = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period_min    <= PERIOD_MIN_RST;
         cfg_ff.period_max    <= PERIOD_MAX_RST;
         cfg_ff.one_threshold <= ONE_THRESHOLD_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PERIOD_MIN:    cfg_ff.period_min    <= csr_wdata;
            CSR_PERIOD_MAX:    cfg_ff.period_max    <= csr_wdata;
            CSR_ONE_THRESHOLD: cfg_ff.one_threshold <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   pwbr_decoder u_decoder (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_word (req_word),
      .cfg      (cfg_ff),
      .push     (push)
   );

   pwbr_rsp_fifo #(
      .RSP_DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

### rtl/core/pwbr_checker.sv
module pwbr_checker
   import pwbr_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   // nothing comes out straight after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled rsp word changed");

   a_byte_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.event_code == EV_BYTE |-> rsp_word.last)
      else $error("byte word not last");

   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.event_code != EV_BYTE |-> rsp_word.data_byte == 8'd0)
      else $error("data byte set on non-byte event");

   // only a lost byte can be followed by a second result
   a_first_lost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.last |-> rsp_word.event_code == EV_LOST)
      else $error("non-final result is not a lost byte");

endmodule

bind pwm_width_byte_receiver_unit pwbr_checker u_pwbr_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

### verif/tb.sv
module tb;
   import pwbr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int               SETTLE_CYCLES = 8;
   localparam logic [1:0]       TALLY_MANY    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_word_type         req_word  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_word_type         rsp_word;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [PERIOD_W-1:0]  csr_wdata = '0;

   // own copy of the receiver state and thresholds
   logic [PERIOD_W-1:0]       period_lo_lim = PERIOD_MIN_RST;
   logic [PERIOD_W-1:0]       period_hi_lim = PERIOD_MAX_RST;
   logic [COUNT_W-1:0]        one_level     = ONE_THRESHOLD_RST;
   logic [0:BITS_PER_FRAME-1] frame_bits    = '0;
   logic [BIT_IDX_W-1:0]      bit_pos       = '0;
   logic                      capture_odd   = 1'b0;
   logic [1:0]                capture_count = '0;
   logic                      link_is_up    = 1'b0;

   rsp_word_type pending_rsp_q[$];
   int           error_count   = 0;
   int           send_gap_pct  = 0;
   int           rsp_stall_pct = 0;

   pwm_width_byte_receiver_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   function automatic void clear_frame_counters();
      bit_pos       = '0;
      capture_count = '0;
      capture_odd   = 1'b0;
   endfunction

   function automatic event_code_type toggle_link();
      clear_frame_counters();
      if (!link_is_up) begin
         link_is_up = 1'b1;
         return EV_CONN;
      end
      link_is_up = 1'b0;
      return EV_DISC;
   endfunction

   function automatic void decode_word(input req_word_type w);
      logic                is_one;
      logic                data_slot;
      logic [PERIOD_W-1:0] period;
      rsp_word_type        r;
      is_one       = (w.high_count > one_level);
      r.event_code = EV_BYTE;
      r.data_byte  = '0;
      r.last       = 1'b1;
      if (w.req_type == REQ_CAPTURE) begin
         data_slot = (capture_count == TALLY_MANY) && !capture_odd;
         if (capture_count != TALLY_MANY) capture_count++;
         capture_odd = ~capture_odd;
         if (data_slot) begin
            period = {1'b0, w.high_count} + {1'b0, w.low_count};
            if (period > period_lo_lim && period < period_hi_lim && bit_pos < BITS_PER_FRAME)
               frame_bits[bit_pos[BIT_SEL_W-1:0]] = is_one;
            if (bit_pos < BITS_PER_FRAME) bit_pos++;
         end
      end else if (capture_count == TALLY_MANY && bit_pos == BITS_PER_FRAME - 1) begin
         frame_bits[BITS_PER_FRAME-1] = is_one;
         r.data_byte = frame_bits;
         pending_rsp_q.push_back(r);
         clear_frame_counters();
         link_is_up = 1'b1;
      end else if (capture_count == TALLY_MANY) begin
         // odd capture count means the link toggles after the lost byte
         r.event_code = EV_LOST;
         r.last       = !capture_odd;
         pending_rsp_q.push_back(r);
         if (capture_odd) begin
            r.event_code = toggle_link();
            r.last       = 1'b1;
            pending_rsp_q.push_back(r);
         end else begin
            clear_frame_counters();
         end
      end else if (capture_count == 2'd1) begin
         r.event_code = toggle_link();
         pending_rsp_q.push_back(r);
      end
   endfunction

   always @(posedge clock) begin : check_rsp
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp_q.size() == 0) begin
            $error("unexpected word: event_code %0d data_byte %0h last %0b",
                   rsp_word.event_code, rsp_word.data_byte, rsp_word.last);
            error_count++;
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_word.event_code !== want.event_code) begin
               $error("event_code: expected %0d, got %0d",
                      want.event_code, rsp_word.event_code);
               error_count++;
            end
            if (rsp_word.data_byte !== want.data_byte) begin
               $error("data_byte: expected %0h, got %0h", want.data_byte, rsp_word.data_byte);
               error_count++;
            end
            if (rsp_word.last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_word.last);
               error_count++;
            end
         end
      end
   end

   // leaves valid high on return; the next send or finish_words decides
   task automatic send_word(input req_word_type w);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_gap_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_word(w);
   endtask

   task automatic finish_words();
      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input logic [PERIOD_W-1:0] lo_lim,
                               input logic [PERIOD_W-1:0] hi_lim,
                               input logic [COUNT_W-1:0]  level);
      logic [CSR_IDX_W-1:0] sel [4];
      logic [PERIOD_W-1:0]  wdata [4];
      sel   = '{CSR_PERIOD_MIN, CSR_PERIOD_MAX, CSR_ONE_THRESHOLD, CSR_SPARE};
      wdata = '{lo_lim, hi_lim, {1'($urandom_range(1)), level}, PERIOD_W'($urandom)};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= sel[i];
         csr_wdata <= wdata[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         case (sel[i])
            CSR_PERIOD_MIN:    period_lo_lim = wdata[i];
            CSR_PERIOD_MAX:    period_hi_lim = wdata[i];
            CSR_ONE_THRESHOLD: one_level     = wdata[i][COUNT_W-1:0];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   function automatic req_word_type make_word(input logic kind, input int hi, input int lo);
      req_word_type w;
      w.req_type   = kind;
      w.high_count = COUNT_W'(hi);
      w.low_count  = COUNT_W'(lo);
      return w;
   endfunction

   // a data capture, mostly with a period inside the current bounds
   function automatic req_word_type data_capture(input int bad_pct);
      req_word_type w;
      int           period;
      int           hi_min;
      int           hi_max;
      w = make_word(REQ_CAPTURE, $urandom, $urandom);
      if (period_hi_lim > period_lo_lim + 1 && $urandom_range(99) >= bad_pct) begin
         period = $urandom_range(period_hi_lim - 1, period_lo_lim + 1);
         hi_min = (period > 65535) ? period - 65535 : 0;
         hi_max = (period > 65535) ? 65535 : period;
         w.high_count = COUNT_W'($urandom_range(hi_max, hi_min));
         if ($urandom_range(3) == 0 && one_level >= hi_min && one_level < hi_max)
            w.high_count = one_level + COUNT_W'($urandom_range(1));
         w.low_count = COUNT_W'(period - w.high_count);
      end
      return w;
   endfunction

   function automatic req_word_type closing_idle();
      if ($urandom_range(3) == 0)
         return make_word(REQ_IDLE, one_level + $urandom_range(1), $urandom);
      return make_word(REQ_IDLE, $urandom, $urandom);
   endfunction

   task automatic send_frame(input int data_bits, input bit extra, input int bad_pct);
      send_word(make_word(REQ_CAPTURE, $urandom, $urandom));
      repeat (data_bits) begin
         send_word(make_word(REQ_CAPTURE, $urandom, $urandom));
         send_word(data_capture(bad_pct));
      end
      if (extra) send_word(make_word(REQ_CAPTURE, $urandom, $urandom));
      send_word(closing_idle());
   endtask

   task automatic run_traffic(input int units);
      int pick;
      repeat (units) begin
         pick = $urandom_range(99);
         if (pick < 62)
            send_frame(BITS_PER_FRAME - 1, 1'b0, 10);
         else if (pick < 74)
            send_frame($urandom_range(BITS_PER_FRAME - 2), 1'($urandom_range(1)), 20);
         else if (pick < 80)
            send_frame($urandom_range(BITS_PER_FRAME + 2, BITS_PER_FRAME),
                       1'($urandom_range(1)), 20);
         else if (pick < 86)
            send_frame(0, 1'b0, 0);
         else if (pick < 90)
            send_word(make_word(REQ_IDLE, $urandom, $urandom));
         else
            repeat ($urandom_range(6, 1))
               send_word(make_word(1'($urandom_range(1)), $urandom, $urandom));
      end
      finish_words();
   endtask

   function automatic logic [PERIOD_W-1:0] random_lo_lim();
      return PERIOD_W'($urandom_range(60000, 40000));
   endfunction

   // reset thresholds, every frame outcome once
   task automatic test_directed();
      int data_hi [7];
      int data_lo [7];
      data_hi = '{40000, 20000, 30001, 30000, 40000, 40000, 20000};
      data_lo = '{20000, 40000, 30000, 30000, 26000, 14000, 40000};
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      send_word(make_word(REQ_IDLE, 0, 0));
      send_word(make_word(REQ_CAPTURE, 65535, 65535));
      send_word(make_word(REQ_IDLE, 65535, 65535));
      // full frame, two bits on the period bounds exactly
      send_word(make_word(REQ_CAPTURE, 0, 0));
      for (int i = 0; i < 7; i++) begin
         send_word(make_word(REQ_CAPTURE, (i % 2) ? 0 : 65535, (i % 2) ? 0 : 65535));
         send_word(make_word(REQ_CAPTURE, data_hi[i], data_lo[i]));
      end
      send_word(make_word(REQ_IDLE, 30001, 0));
      // short frame, odd captures: lost byte then link drop
      send_word(make_word(REQ_CAPTURE, 100, 200));
      send_word(make_word(REQ_CAPTURE, 300, 400));
      send_word(make_word(REQ_CAPTURE, 40000, 20000));
      send_word(make_word(REQ_IDLE, 0, 65535));
      // short frame, even captures: lost byte alone
      send_word(make_word(REQ_CAPTURE, 1, 2));
      send_word(make_word(REQ_CAPTURE, 3, 4));
      send_word(make_word(REQ_IDLE, 5, 6));
      finish_words();
   endtask

   task automatic test_frames_no_idling();
      logic [PERIOD_W-1:0] lo_lim;
      lo_lim = random_lo_lim();
      write_config(lo_lim, lo_lim + PERIOD_W'($urandom_range(20000, 2)),
                   COUNT_W'($urandom_range(40000, 20000)));
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      run_traffic(30);
   endtask

   task automatic test_sender_gaps();
      write_config('0, PERIOD_W'(131070), COUNT_W'(65535));
      send_gap_pct  = 75;
      rsp_stall_pct = 0;
      run_traffic(30);
   endtask

   task automatic test_receiver_stalls();
      write_config('0, PERIOD_W'(131070), '0);
      send_gap_pct  = 0;
      rsp_stall_pct = 75;
      run_traffic(30);
   endtask

   task automatic test_both_idle();
      logic [PERIOD_W-1:0] lo_lim;
      lo_lim = random_lo_lim();
      write_config(lo_lim, lo_lim + PERIOD_W'($urandom_range(30000, 2)), COUNT_W'($urandom));
      send_gap_pct  = 22;
      rsp_stall_pct = 22;
      run_traffic(30);
   endtask

   // no period can pass, so bytes carry bits left from earlier frames
   task automatic test_closed_window();
      write_config(PERIOD_W'(131070), '0, COUNT_W'($urandom));
      send_gap_pct  = 22;
      rsp_stall_pct = 22;
      run_traffic(15);
      write_config(PERIOD_W'(60000), PERIOD_W'(60001), ONE_THRESHOLD_RST);
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      run_traffic(15);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_frames_no_idling();
      test_sender_gaps();
      test_receiver_stalls();
      test_both_idle();
      test_closed_window();
      if (error_count == 0 && pending_rsp_q.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("tb NOT OK");
      $finish;
   end

endmodule

### files.f
rtl/core/pwbr_pkg.sv
rtl/core/pwbr_decoder.sv
rtl/core/pwbr_rsp_fifo.sv
rtl/core/pwm_width_byte_receiver_unit.sv
rtl/core/pwbr_checker.sv
verif/tb.sv
